// ===== hdl/cwme_pkg.sv =====
// ---------------------------------------------------------------------------
// Centered window envelope package
// Shared types and constants of the windowed min/max envelope block.
// ---------------------------------------------------------------------------
package cwme_pkg;

    localparam int PTR_W    = 7;
    localparam int STAMP_W  = 8;
    localparam int RADIUS_W = 6;
    localparam int SEEN_W   = 7;
    localparam int ADDR_W   = PTR_W + 1;
    localparam int DEPTH    = 1 << ADDR_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXP_RD,
        S_EXP_CHK,
        S_EXP_DONE,
        S_PUSH_RD,
        S_PUSH_CHK,
        S_PUSH_WR,
        S_POST,
        S_EMIT_A,
        S_EMIT_B,
        S_EMIT_C,
        S_OUT
    } t_state;

endpackage

// ===== hdl/centered_window_min_max_envelope.sv =====
// An item runs its two deque updates, expiring old entries and dropping dominated ones,
// then reads both deque heads and offers a result word. Each flushed result at the end
// of a series first expires old entries from both deques. The rate is set by the one
// deque memory, read one entry per compare step; a new sample is taken only when idle.
// Reset (synchronous, active low) empties both deques, clears position and count,
// and sets the radius to 5.
// ---------------------------------------------------------------------------
// Centered window min/max envelope
// Gives the minimum and maximum over a window of 2k+1 samples centered on each
// sample position, using two monotonic deques kept in one shared memory.
// ---------------------------------------------------------------------------
module centered_window_min_max_envelope
    import cwme_pkg::*;
#(
    parameter int MAX_RADIUS  = 63,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [RADIUS_W-1:0]                    i_cfg_wdata,
    input  logic                                   i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // Fields from bit 0: sample.
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       i_s_axis_tdata,
    input  logic                                   i_s_axis_tlast,
    output logic                                   o_m_axis_tvalid,
    input  logic                                   i_m_axis_tready,
    // Fields from bit 0: lower, upper.
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     o_m_axis_tdata,
    output logic                                   o_m_axis_tlast
);

    localparam int OUT_W = ((2*SAMPLE_BITS+7)/8)*8;
    localparam int MEM_W = SAMPLE_BITS + STAMP_W;
    localparam logic [RADIUS_W-1:0] RST_RADIUS =
        (5 > MAX_RADIUS) ? RADIUS_W'(MAX_RADIUS) : RADIUS_W'(5);
    localparam logic [SEEN_W-1:0] SEEN_MAX = '1;

    t_state                         r_state, n_state;
    logic                           r_sel, n_sel;
    logic                           r_flush, n_flush;
    logic [PTR_W-1:0]               r_head [2];
    logic [PTR_W-1:0]               n_head [2];
    logic [PTR_W-1:0]               r_tail [2];
    logic [PTR_W-1:0]               n_tail [2];
    logic [STAMP_W-1:0]             r_position, n_position;
    logic [SEEN_W-1:0]              r_seen, n_seen;
    logic [RADIUS_W-1:0]            r_radius;
    logic signed [SAMPLE_BITS-1:0]  r_key, n_key;
    logic                           r_end, n_end;
    logic [RADIUS_W-1:0]            r_k, n_k;
    logic [STAMP_W-1:0]             r_p, n_p;
    logic [PTR_W-1:0]               r_lim, n_lim;
    logic [RADIUS_W-1:0]            r_d, n_d;
    logic                           r_last, n_last;
    logic signed [SAMPLE_BITS-1:0]  r_lower, n_lower;
    logic signed [SAMPLE_BITS-1:0]  r_upper, n_upper;

    logic [MEM_W-1:0]               r_mem [DEPTH];
    logic [MEM_W-1:0]               r_rdata;
    logic [ADDR_W-1:0]              mem_raddr;
    logic [ADDR_W-1:0]              mem_waddr;
    logic [MEM_W-1:0]               mem_wdata;
    logic                           mem_we;

    logic signed [SAMPLE_BITS-1:0]  rd_value;
    logic [STAMP_W-1:0]             rd_stamp;
    logic [STAMP_W-1:0]             age;
    logic [RADIUS_W-1:0]            count;
    logic                           dominated;

    assign rd_value  = r_rdata[MEM_W-1:STAMP_W];
    assign rd_stamp  = r_rdata[STAMP_W-1:0];
    assign age       = r_p - rd_stamp;
    assign count     = (r_seen < {1'b0, r_k}) ? r_seen[RADIUS_W-1:0] : r_k;
    assign dominated = (r_sel == 1'b0) ? (rd_value >= r_key) : (rd_value <= r_key);

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = (r_state == S_OUT);
    assign o_m_axis_tdata  = OUT_W'({r_upper, r_lower});
    assign o_m_axis_tlast  = r_last;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RST_RADIUS;
        end else if (i_cfg_we) begin
            r_radius <= (i_cfg_wdata > RADIUS_W'(MAX_RADIUS)) ?
                        RADIUS_W'(MAX_RADIUS) : i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_sel      <= 1'b0;
            r_flush    <= 1'b0;
            r_head     <= '{default: '0};
            r_tail     <= '{default: '0};
            r_position <= '0;
            r_seen     <= '0;
            r_last     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_sel      <= n_sel;
            r_flush    <= n_flush;
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_position <= n_position;
            r_seen     <= n_seen;
            r_last     <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_end   <= n_end;
        r_k     <= n_k;
        r_p     <= n_p;
        r_lim   <= n_lim;
        r_d     <= n_d;
        r_lower <= n_lower;
        r_upper <= n_upper;
    end

    always_comb begin
        n_state    = r_state;
        n_sel      = r_sel;
        n_flush    = r_flush;
        n_head     = r_head;
        n_tail     = r_tail;
        n_position = r_position;
        n_seen     = r_seen;
        n_key      = r_key;
        n_end      = r_end;
        n_k        = r_k;
        n_p        = r_p;
        n_lim      = r_lim;
        n_d        = r_d;
        n_last     = r_last;
        n_lower    = r_lower;
        n_upper    = r_upper;
        mem_raddr  = {r_sel, r_head[r_sel]};
        mem_waddr  = {r_sel, r_tail[r_sel]};
        mem_wdata  = {r_key, r_p};
        mem_we     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_key   = i_s_axis_tdata[SAMPLE_BITS-1:0];
                    n_end   = i_s_axis_tlast;
                    n_k     = r_radius;
                    n_p     = r_position;
                    n_lim   = {r_radius, 1'b0};
                    n_flush = 1'b0;
                    n_sel   = 1'b0;
                    n_state = S_EXP_RD;
                end
            end
            S_EXP_RD: begin
                if (r_head[r_sel] == r_tail[r_sel]) begin
                    n_state = S_EXP_DONE;
                end else begin
                    n_state = S_EXP_CHK;
                end
            end
            S_EXP_CHK: begin
                if (age > {1'b0, r_lim}) begin
                    n_head[r_sel] = r_head[r_sel] + 1'b1;
                    n_state       = S_EXP_RD;
                end else begin
                    n_state = S_EXP_DONE;
                end
            end
            S_EXP_DONE: begin
                if (!r_flush) begin
                    n_state = S_PUSH_RD;
                end else if (r_sel == 1'b0) begin
                    n_sel   = 1'b1;
                    n_state = S_EXP_RD;
                end else begin
                    n_state = S_EMIT_A;
                end
            end
            S_PUSH_RD: begin
                mem_raddr = {r_sel, r_tail[r_sel] - 1'b1};
                if (r_tail[r_sel] == r_head[r_sel]) begin
                    n_state = S_PUSH_WR;
                end else begin
                    n_state = S_PUSH_CHK;
                end
            end
            S_PUSH_CHK: begin
                if (dominated) begin
                    n_tail[r_sel] = r_tail[r_sel] - 1'b1;
                    n_state       = S_PUSH_RD;
                end else begin
                    n_state = S_PUSH_WR;
                end
            end
            S_PUSH_WR: begin
                mem_we        = 1'b1;
                n_tail[r_sel] = r_tail[r_sel] + 1'b1;
                if (r_sel == 1'b0) begin
                    n_sel   = 1'b1;
                    n_state = S_EXP_RD;
                end else begin
                    n_position = r_p + 1'b1;
                    if (r_seen != SEEN_MAX) begin
                        n_seen = r_seen + 1'b1;
                    end
                    n_state = S_POST;
                end
            end
            S_POST: begin
                if (r_seen > {1'b0, r_k}) begin
                    n_last  = r_end && (count == '0);
                    n_state = S_EMIT_A;
                end else if (r_end) begin
                    n_flush = 1'b1;
                    n_d     = count;
                    n_lim   = PTR_W'({1'b0, count} - 1'b1 + {1'b0, r_k});
                    n_last  = (count == RADIUS_W'(1));
                    n_sel   = 1'b0;
                    n_state = S_EXP_RD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT_A: begin
                mem_raddr = {1'b0, r_head[0]};
                n_state   = S_EMIT_B;
            end
            S_EMIT_B: begin
                mem_raddr = {1'b1, r_head[1]};
                n_lower   = rd_value;
                n_state   = S_EMIT_C;
            end
            S_EMIT_C: begin
                n_upper = rd_value;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_m_axis_tready) begin
                    if ((r_flush && r_d == RADIUS_W'(1)) ||
                        (!r_flush && r_end && count == '0)) begin
                        n_head     = '{default: '0};
                        n_tail     = '{default: '0};
                        n_position = '0;
                        n_seen     = '0;
                        n_state    = S_IDLE;
                    end else if (r_flush) begin
                        n_d     = r_d - 1'b1;
                        n_lim   = r_lim - 1'b1;
                        n_last  = (r_d == RADIUS_W'(2));
                        n_sel   = 1'b0;
                        n_state = S_EXP_RD;
                    end else if (r_end) begin
                        n_flush = 1'b1;
                        n_d     = count;
                        n_lim   = PTR_W'({1'b0, count} - 1'b1 + {1'b0, r_k});
                        n_last  = (count == RADIUS_W'(1));
                        n_sel   = 1'b0;
                        n_state = S_EXP_RD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_ready_not_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> !o_m_axis_tvalid)
        else $error("input ready while a result word is pending");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input ready right after a word was accepted");

    a_radius_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_radius <= RADIUS_W'(MAX_RADIUS))
        else $error("radius above its maximum");

    a_empty_at_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_seen == '0) |->
            (r_position == '0 && r_head[0] == r_tail[0] && r_head[1] == r_tail[1]))
        else $error("deques or position not cleared at series start");
`endif

endmodule

// ===== bench/cwme_envelope_checker.sv =====
// ---------------------------------------------------------------------------
// Centered window envelope checker
// Watches the radius writes and both stream channels of the envelope block.
// It keeps its own pair of monotonic deques, predicts the lower and upper
// envelope words for every accepted sample, and compares each output word
// field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module cwme_envelope_checker
    import cwme_pkg::*;
#(
    parameter int SAMPLE_BITS = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [RADIUS_W-1:0]      i_cfg_wdata,
    input  logic                     i_s_tvalid,
    input  logic                     i_s_tready,
    input  logic [SAMPLE_BITS-1:0]   i_s_tdata,
    input  logic                     i_s_tlast,
    input  logic                     i_m_tvalid,
    input  logic                     i_m_tready,
    input  logic [2*SAMPLE_BITS-1:0] i_m_tdata,
    input  logic                     i_m_tlast,
    output int                       o_fail_count,
    output int                       o_pending,
    output int                       o_word_count
);

    localparam int                QDEPTH   = 1 << PTR_W;
    localparam logic [SEEN_W-1:0] SEEN_MAX = {SEEN_W{1'b1}};
    localparam int                MAX_SHOWN = 40;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    typedef struct packed {
        t_sample lower;
        t_sample upper;
        logic    series_last;
    } t_envelope;

    t_sample              lo_val   [QDEPTH];
    logic [STAMP_W-1:0]   lo_stamp [QDEPTH];
    logic [PTR_W-1:0]     lo_head;
    logic [PTR_W-1:0]     lo_tail;
    t_sample              hi_val   [QDEPTH];
    logic [STAMP_W-1:0]   hi_stamp [QDEPTH];
    logic [PTR_W-1:0]     hi_head;
    logic [PTR_W-1:0]     hi_tail;
    logic [STAMP_W-1:0]   next_pos;
    logic [SEEN_W-1:0]    seen;
    logic [RADIUS_W-1:0]  radius;
    t_envelope            envelope_q[$];

    task automatic clear_window();
        lo_head  = '0;
        lo_tail  = '0;
        hi_head  = '0;
        hi_tail  = '0;
        next_pos = '0;
        seen     = '0;
    endtask

    // Entries older than lim, counted from the sample stamped newest, leave the heads.
    task automatic retire_old(input logic [STAMP_W-1:0] newest, input int unsigned lim);
        logic [STAMP_W-1:0] age;
        bit                 more;
        more = 1'b1;
        while (more && lo_head != lo_tail) begin
            age = newest - lo_stamp[lo_head];
            if (age > lim) begin
                lo_head = lo_head + 1'b1;
            end else begin
                more = 1'b0;
            end
        end
        more = 1'b1;
        while (more && hi_head != hi_tail) begin
            age = newest - hi_stamp[hi_head];
            if (age > lim) begin
                hi_head = hi_head + 1'b1;
            end else begin
                more = 1'b0;
            end
        end
    endtask

    task automatic insert_sample(input t_sample v);
        logic [PTR_W-1:0] b;
        bit               more;
        more = 1'b1;
        while (more && lo_tail != lo_head) begin
            b = lo_tail - 1'b1;
            if (lo_val[b] >= v) begin
                lo_tail = b;
            end else begin
                more = 1'b0;
            end
        end
        lo_val[lo_tail]   = v;
        lo_stamp[lo_tail] = next_pos;
        lo_tail           = lo_tail + 1'b1;
        more = 1'b1;
        while (more && hi_tail != hi_head) begin
            b = hi_tail - 1'b1;
            if (hi_val[b] <= v) begin
                hi_tail = b;
            end else begin
                more = 1'b0;
            end
        end
        hi_val[hi_tail]   = v;
        hi_stamp[hi_tail] = next_pos;
        hi_tail           = hi_tail + 1'b1;
    endtask

    task automatic queue_envelope();
        envelope_q.push_back('{lower: lo_val[lo_head], upper: hi_val[hi_head],
                               series_last: 1'b0});
    endtask

    task automatic take_sample(input t_sample v, input logic ends);
        int unsigned k;
        int unsigned flush_n;
        int          made;
        k    = radius;
        made = 0;
        retire_old(next_pos, 2 * k);
        insert_sample(v);
        next_pos = next_pos + 1'b1;
        if (seen < SEEN_MAX) begin
            seen = seen + 1'b1;
        end
        if (seen > k) begin
            queue_envelope();
            made++;
        end
        if (ends) begin
            // The positions still pending each get their own clipped window.
            flush_n = (seen < k) ? seen : k;
            for (int d = flush_n; d > 0; d--) begin
                retire_old(next_pos - 1'b1, d - 1 + k);
                queue_envelope();
                made++;
            end
            if (made > 0) begin
                envelope_q[envelope_q.size() - 1].series_last = 1'b1;
            end
            clear_window();
        end
    endtask

    task automatic check_word();
        t_envelope want;
        t_sample   got_lo;
        t_sample   got_hi;
        got_lo = i_m_tdata[SAMPLE_BITS-1:0];
        got_hi = i_m_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
        o_word_count++;
        if (envelope_q.size() == 0) begin
            o_fail_count++;
            if (o_fail_count <= MAX_SHOWN) begin
                $display("%0t: unexpected word, expected none, got lower %0d upper %0d last %0b",
                         $time, got_lo, got_hi, i_m_tlast);
            end
        end else begin
            want = envelope_q.pop_front();
            if (got_lo !== want.lower) begin
                o_fail_count++;
                if (o_fail_count <= MAX_SHOWN) begin
                    $display("%0t: lower expected %0d, got %0d", $time, want.lower, got_lo);
                end
            end
            if (got_hi !== want.upper) begin
                o_fail_count++;
                if (o_fail_count <= MAX_SHOWN) begin
                    $display("%0t: upper expected %0d, got %0d", $time, want.upper, got_hi);
                end
            end
            if (i_m_tlast !== want.series_last) begin
                o_fail_count++;
                if (o_fail_count <= MAX_SHOWN) begin
                    $display("%0t: last expected %0b, got %0b", $time, want.series_last,
                             i_m_tlast);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_window();
            radius = RADIUS_W'(5);
            envelope_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                check_word();
            end
            if (i_cfg_we) begin
                radius = i_cfg_wdata;
            end
            if (i_s_tvalid && i_s_tready) begin
                take_sample(i_s_tdata, i_s_tlast);
            end
        end
        o_pending = envelope_q.size();
    end

endmodule

// ===== bench/tb.sv =====
// ---------------------------------------------------------------------------
// Centered window envelope testbench
// Drives series of samples into the envelope block under several radius
// settings, with random gaps on both stream sides, a long output stall and a
// series long enough to wrap the position stamps. The checker beside the
// block predicts and compares every envelope word.
// ---------------------------------------------------------------------------
module tb;
    import cwme_pkg::*;

    localparam int SB            = 32;
    localparam int RAD_MAX       = 63;
    localparam int SETTLE_CYCLES = 300;
    localparam int RANDOM_ITEMS  = 45;
    localparam int LONG_LEN      = 260;
    localparam int HOLD_CYCLES   = 400;

    typedef enum int {
        PAT_RANDOM,
        PAT_EXTREME,
        PAT_TIGHT,
        PAT_RAMP
    } t_pattern;

    logic                i_clk     = 1'b0;
    logic                i_rst_n   = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [RADIUS_W-1:0] cfg_wdata = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [SB-1:0]       s_tdata   = '0;   // Fields from bit 0: sample.
    logic                s_tlast   = 1'b0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [2*SB-1:0]     m_tdata;          // Fields from bit 0: lower, upper.
    logic                m_tlast;

    int fail_count;
    int pending;
    int words_checked;
    int samples_sent  = 0;
    int series_sent   = 0;
    int radius_writes = 0;
    int hold_left     = 0;
    bit hold_done     = 1'b0;
    bit long_active   = 1'b0;
    int long_sent     = 0;
    bit tx_calm       = 1'b0;

    centered_window_min_max_envelope uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast)
    );

    cwme_envelope_checker #(
        .SAMPLE_BITS (SB)
    ) checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_word_count (words_checked)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // The receiver stalls at random, holds off once for a long stretch in the
    // middle of the long series, and takes a run of words without any stall.
    initial begin
        forever begin
            @(negedge i_clk);
            if (!hold_done && long_active && long_sent >= 80) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_tready = 1'b0;
                hold_left--;
            end else if (words_checked >= 200 && words_checked < 280) begin
                m_tready = 1'b1;
            end else begin
                m_tready = ($urandom_range(0, 99) >= 26);
            end
        end
    end

    task automatic send_word(input logic [SB-1:0] v, input bit ends);
        @(negedge i_clk);
        while (!tx_calm && $urandom_range(0, 99) < 26) begin
            s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = v;
        s_tlast  = ends;
        do begin
            @(posedge i_clk);
        end while (!s_tready);
        samples_sent++;
        if (ends) begin
            series_sent++;
        end
    endtask

    // Radius writes happen only with the block drained and settled.
    task automatic set_radius(input int unsigned r);
        @(negedge i_clk);
        s_tvalid = 1'b0;
        s_tlast  = 1'b0;
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        cfg_we    = 1'b1;
        cfg_wdata = r[RADIUS_W-1:0];
        radius_writes++;
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    task automatic run_series(input int len, input t_pattern pat);
        logic [SB-1:0] v;
        logic [SB-1:0] step;
        v    = $urandom;
        step = $urandom_range(1, 1000);
        if ($urandom_range(0, 1) == 1) begin
            step = -step;
        end
        for (int i = 0; i < len; i++) begin
            case (pat)
                PAT_RANDOM: begin
                    v = $urandom;
                end
                PAT_EXTREME: begin
                    case ($urandom_range(0, 4))
                        0: v = 32'h8000_0000;
                        1: v = 32'h7FFF_FFFF;
                        2: v = 32'h0000_0000;
                        3: v = 32'hFFFF_FFFF;
                        default: v = 32'h0000_0001;
                    endcase
                end
                PAT_TIGHT: begin
                    v = $urandom_range(0, 6) - 3;
                end
                default: begin
                    v = v + step;
                end
            endcase
            tx_calm = long_active && i >= 100 && i < 180;
            send_word(v, i == len - 1);
            if (long_active) begin
                long_sent = i + 1;
            end
        end
        tx_calm = 1'b0;
    endtask

    initial begin
        int       ph;
        int       k;
        int       nser;
        int       len;
        int       hi_len;
        int       directed_end;
        t_pattern pat;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: single sample at the reset radius, radius zero, a short series
        // at the largest radius, ties and extremes, and a radius change mid-series.
        send_word(32'h7FFF_FFFF, 1'b1);
        set_radius(0);
        send_word(32'h8000_0000, 1'b0);
        send_word(32'h7FFF_FFFF, 1'b0);
        send_word(32'h0000_0000, 1'b1);
        set_radius(RAD_MAX);
        send_word(5, 1'b0);
        send_word(-5, 1'b0);
        send_word(32'h8000_0000, 1'b0);
        send_word(32'h7FFF_FFFF, 1'b1);
        set_radius(3);
        send_word(-1, 1'b0);
        send_word(7, 1'b0);
        send_word(7, 1'b0);
        send_word(32'h8000_0000, 1'b0);
        send_word(7, 1'b0);
        send_word(-1, 1'b1);
        set_radius(2);
        send_word(10, 1'b0);
        send_word(20, 1'b0);
        send_word(30, 1'b0);
        send_word(40, 1'b0);
        set_radius(4);
        send_word(-10, 1'b0);
        send_word(50, 1'b0);
        send_word(5, 1'b1);
        directed_end = samples_sent;

        ph = 0;
        while (samples_sent < directed_end + RANDOM_ITEMS) begin
            if (ph == 0) begin
                k = 0;
            end else if (ph == 1) begin
                k = 1;
            end else if (ph == 2) begin
                k = RAD_MAX;
            end else if ($urandom_range(0, 3) == 0) begin
                k = $urandom_range(0, RAD_MAX);
            end else begin
                k = $urandom_range(0, 8);
            end
            set_radius(k);
            nser = $urandom_range(1, 3);
            for (int s = 0; s < nser; s++) begin
                hi_len = 2 * k + 6;
                if (hi_len > 40) begin
                    hi_len = 40;
                end
                len = $urandom_range(1, hi_len);
                pat = t_pattern'($urandom_range(0, 3));
                run_series(len, pat);
            end
            ph++;
        end

        // One ramp at the largest radius, long enough to wrap the position stamps.
        set_radius(RAD_MAX);
        long_active = 1'b1;
        run_series(LONG_LEN, PAT_RAMP);
        long_active = 1'b0;

        @(negedge i_clk);
        s_tvalid = 1'b0;
        s_tlast  = 1'b0;
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d samples in %0d series under %0d radius writes, 0 to %0d.",
                 samples_sent, series_sent, radius_writes, RAD_MAX);
        $display("Checked %0d envelope words, including a stamp-wrapping series.",
                 words_checked);
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
